[hw/rtl/fifo_queue_with_stable_partition_assert.svh]
// Assertion macros for the task queue with stable partition.
// Used by the checker module; needs clk and rst_n in the scope of use.
`ifndef FIFO_QUEUE_WITH_STABLE_PARTITION_ASSERT_SVH
`define FIFO_QUEUE_WITH_STABLE_PARTITION_ASSERT_SVH

// Check a property while out of reset.
`define FQSP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fqsp check failed");

// Check a property at every edge, reset included.
`define FQSP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fqsp reset check failed");

`endif

[hw/rtl/fqsp_pkg.sv]
// Package for the task queue with stable partition: sizes, codes, entry type
// and the microcode table of the sequencer. No dependencies.
`default_nettype none

package fqsp_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int ACT_W  = 3;
  localparam int REW_W  = 16;
  localparam int KIND_W = 8;
  localparam int DUR_W  = 16;
  localparam int ST_W   = 2;
  localparam int TOT_W  = 22;

  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  localparam logic [ACT_W-1:0] ACT_PUSH      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PARTITION = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [REW_W-1:0]  reward;
    logic [KIND_W-1:0] kind;
    logic [DUR_W-1:0]  duration;
  } entry_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    entry_t           ent;
    logic [TOT_W-1:0] total;
  } result_t;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] S_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] S_PUSH     = 5'd1;
  localparam logic [PC_W-1:0] S_FULL     = 5'd2;
  localparam logic [PC_W-1:0] S_EMPTY    = 5'd3;
  localparam logic [PC_W-1:0] S_HEAD_RD  = 5'd4;
  localparam logic [PC_W-1:0] S_HEAD_OUT = 5'd5;
  localparam logic [PC_W-1:0] S_CLEAR    = 5'd6;
  localparam logic [PC_W-1:0] S_NOP      = 5'd7;
  localparam logic [PC_W-1:0] S_P_INIT   = 5'd8;
  localparam logic [PC_W-1:0] S_P1_RD    = 5'd9;
  localparam logic [PC_W-1:0] S_P1_CHK   = 5'd10;
  localparam logic [PC_W-1:0] S_P2_INIT  = 5'd11;
  localparam logic [PC_W-1:0] S_P2_RD    = 5'd12;
  localparam logic [PC_W-1:0] S_P2_CHK   = 5'd13;
  localparam logic [PC_W-1:0] S_P3_INIT  = 5'd14;
  localparam logic [PC_W-1:0] S_P3_RD    = 5'd15;
  localparam logic [PC_W-1:0] S_P3_WR    = 5'd16;
  localparam logic [PC_W-1:0] S_P_DONE   = 5'd17;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PUSH,
    OP_FULL,
    OP_EMPTY,
    OP_RD_HEAD,
    OP_HEAD_OUT,
    OP_CLEAR,
    OP_NOP,
    OP_P_INIT,
    OP_RD_ENTRY,
    OP_TAKE_MATCH,
    OP_TAKE_OTHER,
    OP_I_CLR,
    OP_RD_SCRATCH,
    OP_COPY,
    OP_P_DONE
  } op_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_ALWAYS,
    C_I_DONE,
    C_DISPATCH
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      S_IDLE:     w = '{op: OP_IDLE,       cond: C_DISPATCH, target: S_IDLE};
      S_PUSH:     w = '{op: OP_PUSH,       cond: C_ALWAYS,   target: S_IDLE};
      S_FULL:     w = '{op: OP_FULL,       cond: C_ALWAYS,   target: S_IDLE};
      S_EMPTY:    w = '{op: OP_EMPTY,      cond: C_ALWAYS,   target: S_IDLE};
      S_HEAD_RD:  w = '{op: OP_RD_HEAD,    cond: C_NEXT,     target: S_IDLE};
      S_HEAD_OUT: w = '{op: OP_HEAD_OUT,   cond: C_ALWAYS,   target: S_IDLE};
      S_CLEAR:    w = '{op: OP_CLEAR,      cond: C_ALWAYS,   target: S_IDLE};
      S_NOP:      w = '{op: OP_NOP,        cond: C_ALWAYS,   target: S_IDLE};
      S_P_INIT:   w = '{op: OP_P_INIT,     cond: C_NEXT,     target: S_IDLE};
      S_P1_RD:    w = '{op: OP_RD_ENTRY,   cond: C_I_DONE,   target: S_P2_INIT};
      S_P1_CHK:   w = '{op: OP_TAKE_MATCH, cond: C_ALWAYS,   target: S_P1_RD};
      S_P2_INIT:  w = '{op: OP_I_CLR,      cond: C_NEXT,     target: S_IDLE};
      S_P2_RD:    w = '{op: OP_RD_ENTRY,   cond: C_I_DONE,   target: S_P3_INIT};
      S_P2_CHK:   w = '{op: OP_TAKE_OTHER, cond: C_ALWAYS,   target: S_P2_RD};
      S_P3_INIT:  w = '{op: OP_I_CLR,      cond: C_NEXT,     target: S_IDLE};
      S_P3_RD:    w = '{op: OP_RD_SCRATCH, cond: C_I_DONE,   target: S_P_DONE};
      S_P3_WR:    w = '{op: OP_COPY,       cond: C_ALWAYS,   target: S_P3_RD};
      S_P_DONE:   w = '{op: OP_P_DONE,     cond: C_ALWAYS,   target: S_IDLE};
      default:    w = '{op: OP_IDLE,       cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fifo_queue_with_stable_partition.sv]
// Task queue with stable partition: ring store, scratch store and a
// microcoded sequencer. Depends on fqsp_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one action beat (push, pop, peek,
//   clear, partition); the output channel out_valid/out_ready returns exactly
//   one result beat per action, in order.
//   Work from accept to result:
//     push, clear, full/empty error, unknown action: the result is set directly
//     pop, peek: one registered read of the entry store, then the result
//     partition: three walks over the queue, each step
//     a read then a use of the single store read port, then the result
//   The microcode step counter handles one action at a time; in_ready is high
//   only when it sits at its idle step and the result buffer can drain.
//   Reset clears the step counter, head, count, result-buffer valid flag and out_valid;
//   stores are not cleared, only live entries are ever read.
//   When the receiver stalls, the output register holds its beat, one more
//   result waits in the result buffer, and in_ready then stays low.
`default_nettype none

module fifo_queue_with_stable_partition
  import fqsp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [REW_W-1:0]  in_entry_reward,
  input  wire logic [KIND_W-1:0] in_entry_kind,
  input  wire logic [DUR_W-1:0]  in_entry_duration,
  input  wire logic [KIND_W-1:0] in_filter_kind,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [REW_W-1:0]       out_reward,
  output logic [KIND_W-1:0]      out_kind,
  output logic [DUR_W-1:0]       out_duration,
  output logic [TOT_W-1:0]       out_reward_total
);

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  entry_t ent_mem [DEPTH];
  entry_t scr_mem [DEPTH];

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic              pend_r, pend_nxt;
  result_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;

  logic [ACT_W-1:0]  act_r;
  entry_t            new_ent_r;
  logic [KIND_W-1:0] filt_r;

  entry_t            ent_rdata_r, scr_rdata_r;
  logic              ent_we, scr_we;
  logic [IDX_W-1:0]  ent_waddr, ent_raddr, scr_waddr, scr_raddr;
  entry_t            ent_wdata, scr_wdata;

  ctrl_t             ctrl;
  logic              i_done;
  logic              drain;
  logic              in_fire;
  logic [PC_W-1:0]   dispatch_pc;
  logic [TOT_W:0]    sum;

  assign ctrl    = ucode(pc_r);
  assign i_done  = (i_r == cnt_r);
  assign drain   = pend_r && (!out_valid_r || out_ready);
  assign in_ready = (pc_r == S_IDLE) && (!pend_r || drain);
  assign in_fire = in_valid && in_ready;
  assign sum     = (TOT_W + 1)'(tot_r) + (TOT_W + 1)'(ent_rdata_r.reward);

  always_comb begin
    case (in_action)
      ACT_PUSH:      dispatch_pc = (cnt_r >= CNT_W'(DEPTH)) ? S_FULL : S_PUSH;
      ACT_POP:       dispatch_pc = (cnt_r == '0) ? S_EMPTY : S_HEAD_RD;
      ACT_PEEK:      dispatch_pc = (cnt_r == '0) ? S_EMPTY : S_HEAD_RD;
      ACT_CLEAR:     dispatch_pc = S_CLEAR;
      ACT_PARTITION: dispatch_pc = (cnt_r == '0) ? S_EMPTY : S_P_INIT;
      default:       dispatch_pc = S_NOP;
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     pc_nxt = pc_r + PC_W'(1);
      C_ALWAYS:   pc_nxt = ctrl.target;
      C_I_DONE:   pc_nxt = i_done ? ctrl.target : pc_r + PC_W'(1);
      C_DISPATCH: pc_nxt = in_fire ? dispatch_pc : S_IDLE;
      default:    pc_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    tot_nxt   = tot_r;
    pend_nxt  = pend_r && !drain;
    res_nxt   = res_r;
    ent_we    = 1'b0;
    scr_we    = 1'b0;
    ent_waddr = i_r[IDX_W-1:0];
    ent_wdata = scr_rdata_r;
    ent_raddr = slot_of(head_r, i_r);
    scr_waddr = n_r[IDX_W-1:0];
    scr_wdata = ent_rdata_r;
    scr_raddr = i_r[IDX_W-1:0];
    case (ctrl.op)
      OP_IDLE: begin
      end
      OP_PUSH: begin
        ent_we    = 1'b1;
        ent_waddr = slot_of(head_r, cnt_r);
        ent_wdata = new_ent_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        pend_nxt  = 1'b1;
        res_nxt   = '{status: ST_OK, ent: '0, total: '0};
      end
      OP_FULL: begin
        pend_nxt = 1'b1;
        res_nxt  = '{status: ST_FULL, ent: '0, total: '0};
      end
      OP_EMPTY: begin
        pend_nxt = 1'b1;
        res_nxt  = '{status: ST_EMPTY, ent: '0, total: '0};
      end
      OP_RD_HEAD: begin
        ent_raddr = head_r;
      end
      OP_HEAD_OUT: begin
        pend_nxt = 1'b1;
        res_nxt  = '{status: ST_OK, ent: ent_rdata_r, total: '0};
        if (act_r == ACT_POP) begin
          head_nxt = slot_of(head_r, CNT_W'(1));
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        cnt_nxt  = '0;
        head_nxt = '0;
        pend_nxt = 1'b1;
        res_nxt  = '{status: ST_OK, ent: '0, total: '0};
      end
      OP_NOP: begin
        pend_nxt = 1'b1;
        res_nxt  = '{status: ST_OK, ent: '0, total: '0};
      end
      OP_P_INIT: begin
        i_nxt   = '0;
        n_nxt   = '0;
        tot_nxt = '0;
      end
      OP_RD_ENTRY: begin
      end
      OP_TAKE_MATCH: begin
        if (ent_rdata_r.kind == filt_r) begin
          scr_we  = 1'b1;
          n_nxt   = n_r + CNT_W'(1);
          tot_nxt = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
        end
        i_nxt = i_r + CNT_W'(1);
      end
      OP_TAKE_OTHER: begin
        if (ent_rdata_r.kind != filt_r) begin
          scr_we = 1'b1;
          n_nxt  = n_r + CNT_W'(1);
        end
        i_nxt = i_r + CNT_W'(1);
      end
      OP_I_CLR: begin
        i_nxt = '0;
      end
      OP_RD_SCRATCH: begin
      end
      OP_COPY: begin
        ent_we = 1'b1;
        i_nxt  = i_r + CNT_W'(1);
      end
      OP_P_DONE: begin
        head_nxt = '0;
        pend_nxt = 1'b1;
        res_nxt  = '{status: ST_OK, ent: '0, total: tot_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (drain) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    n_r   <= n_nxt;
    tot_r <= tot_nxt;
    res_r <= res_nxt;
    if (drain) begin
      out_r <= res_r;
    end
    if (in_fire) begin
      act_r     <= in_action;
      new_ent_r <= '{reward: in_entry_reward, kind: in_entry_kind,
                     duration: in_entry_duration};
      filt_r    <= in_filter_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    scr_rdata_r <= scr_mem[scr_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_reward       = out_r.ent.reward;
  assign out_kind         = out_r.ent.kind;
  assign out_duration     = out_r.ent.duration;
  assign out_reward_total = out_r.total;

endmodule

`default_nettype wire

[hw/rtl/fqsp_checker.sv]
// Port-level checker for the task queue with stable partition, bound to the
// top level. Depends on fqsp_pkg and fifo_queue_with_stable_partition_assert.svh.
`default_nettype none

`include "fifo_queue_with_stable_partition_assert.svh"

module fqsp_checker
  import fqsp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ST_W-1:0]   out_status,
  input wire logic [REW_W-1:0]  out_reward,
  input wire logic [KIND_W-1:0] out_kind,
  input wire logic [DUR_W-1:0]  out_duration,
  input wire logic [TOT_W-1:0]  out_reward_total
);

  logic [ST_W+REW_W+KIND_W+DUR_W+TOT_W-1:0] out_beat;
  logic                                     head_zero;

  assign out_beat  = {out_status, out_reward, out_kind, out_duration, out_reward_total};
  assign head_zero = (out_reward == '0) && (out_kind == '0) && (out_duration == '0);

  `FQSP_ASSERT_ALWAYS(a_reset_drops_out, !rst_n |=> !out_valid)

  `FQSP_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)

  `FQSP_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_beat))

  `FQSP_ASSERT(a_error_zero, out_valid && out_status != ST_OK |-> head_zero && !(|out_reward_total))

  `FQSP_ASSERT(a_total_no_head, out_valid && out_reward_total != '0 |-> head_zero)

endmodule

bind fifo_queue_with_stable_partition fqsp_checker u_fqsp_checker (.*);

`default_nettype wire
